>>> hdl/clfw_pkg.sv
// Shared types and constants for the cotangent Laplacian face weight pipeline.
// Depends on nothing; every other file but clfw_if.sv refers to it by scoped names.
`default_nettype none

package clfw_pkg;

  // Field and datapath widths.
  localparam int IDX_W     = 16;
  localparam int COORD_W   = 24;
  localparam int DIFF_W    = 25;
  localparam int PROD_W    = 50;
  localparam int CROSS_W   = 51;
  localparam int DOT_W     = 52;
  localparam int MAG_W     = 50;
  localparam int HALF_W    = 25;
  localparam int SQ_W      = 102;
  localparam int ROOT_W    = 51;
  localparam int REM_W     = 103;
  localparam int QUO_W     = 40;
  localparam int FRAC_W    = 16;
  localparam int DIV_SHIFT = 24;
  localparam int COT_MAG_W = 41;
  localparam int COT_W     = 42;
  localparam int WGT_W     = 32;
  localparam int SLOT_N    = 9;
  localparam int SLOT_W    = 4;

  // Vertex indices at or above this bound drop the whole triangle.
  localparam logic [24:0] MAX_VERTICES = 25'd65536;

  // Largest cotangent magnitude, 2^24 in 16 fraction bits.
  localparam logic [COT_MAG_W-1:0] COT_CAP = 41'h100_0000_0000;

  // Uniform weights: 1.0 on the diagonal and -0.5 off it.
  localparam logic [WGT_W-1:0] WGT_ONE      = 32'h0001_0000;
  localparam logic [WGT_W-1:0] WGT_HALF_NEG = 32'hFFFF_8000;
  localparam logic [WGT_W-1:0] WGT_POS_MAX  = 32'h7FFF_FFFF;
  localparam logic [WGT_W-1:0] WGT_NEG_MAX  = 32'h8000_0000;

  // Slot of the ninth triplet of a face.
  localparam logic [SLOT_W-1:0] LAST_SLOT = 4'd8;

  // One triangle as it enters; corner 0 is a, coordinate 0 is x.
  typedef struct packed {
    logic [2:0][IDX_W-1:0]          idx;
    logic [2:0][2:0][COORD_W-1:0]   p;
  } face_t;

  // Data that rides beside the root extraction.
  typedef struct packed {
    logic [2:0][IDX_W-1:0] idx;
    logic [2:0][DOT_W-1:0] dot;
  } side_t;

  // Signed cotangents of the three corners with their flags.
  typedef struct packed {
    logic [2:0][IDX_W-1:0] idx;
    logic [2:0][COT_W-1:0] cot;
    logic [2:0]            flag;
  } cot_t;

endpackage

`default_nettype wire

>>> hdl/clfw_if.sv
// Handshake channels of the block: one triangle in, one matrix triplet out.
// Independent of the package; both carry valid, ready and the payload.
`default_nettype none

interface clfw_face_if;
  logic        valid;
  logic        ready;
  logic [15:0] index_a;
  logic [15:0] index_b;
  logic [15:0] index_c;
  logic [23:0] a_x;
  logic [23:0] a_y;
  logic [23:0] a_z;
  logic [23:0] b_x;
  logic [23:0] b_y;
  logic [23:0] b_z;
  logic [23:0] c_x;
  logic [23:0] c_y;
  logic [23:0] c_z;

  modport source (output valid, index_a, index_b, index_c, a_x, a_y, a_z,
                  b_x, b_y, b_z, c_x, c_y, c_z, input ready);
  modport sink (input valid, index_a, index_b, index_c, a_x, a_y, a_z,
                b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

interface clfw_trip_if;
  logic        valid;
  logic        ready;
  logic [15:0] row_index;
  logic [15:0] col_index;
  logic [31:0] weight;
  logic        saturated;
  logic        last_of_face;

  modport source (output valid, row_index, col_index, weight, saturated, last_of_face,
                  input ready);
  modport sink (input valid, row_index, col_index, weight, saturated, last_of_face,
                output ready);
endinterface

`default_nettype wire

>>> hdl/clfw_front.sv
// Front pipeline: edge vectors, products, cross product, dot products and the
// squared cross-product length over seven register stages. Uses clfw_pkg.
`default_nettype none

module clfw_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  clfw_pkg::face_t             in_face,
  output logic                        out_valid,
  output logic [clfw_pkg::SQ_W-1:0]   out_s,
  output clfw_pkg::side_t             out_side
);

  logic [6:0] vld;
  logic       idx_ok;

  logic signed [clfw_pkg::DIFF_W-1:0]  u [3];
  logic signed [clfw_pkg::DIFF_W-1:0]  v [3];
  logic signed [clfw_pkg::DIFF_W-1:0]  w [3];
  logic signed [clfw_pkg::PROD_W-1:0]  px [6];
  logic signed [clfw_pkg::PROD_W-1:0]  pd [9];
  logic signed [clfw_pkg::CROSS_W-1:0] c [3];
  logic        [clfw_pkg::MAG_W-1:0]   m [3];
  logic        [clfw_pkg::PROD_W-1:0]  hh [3];
  logic        [clfw_pkg::PROD_W-1:0]  hl [3];
  logic        [clfw_pkg::PROD_W-1:0]  ll [3];
  logic        [clfw_pkg::SQ_W-1:0]    sq [3];
  logic [2:0][clfw_pkg::IDX_W-1:0]     idx1;
  logic [2:0][clfw_pkg::IDX_W-1:0]     idx2;
  clfw_pkg::side_t                     side3;
  clfw_pkg::side_t                     side4;
  clfw_pkg::side_t                     side5;
  clfw_pkg::side_t                     side6;

  // A triangle with an index beyond the vertex range produces nothing.
  assign idx_ok = ({9'd0, in_face.idx[0]} < clfw_pkg::MAX_VERTICES) &&
                  ({9'd0, in_face.idx[1]} < clfw_pkg::MAX_VERTICES) &&
                  ({9'd0, in_face.idx[2]} < clfw_pkg::MAX_VERTICES);

  // Valid bits travel with the stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:0], in_valid && idx_ok};
    end
  end

  // Datapath stages.
  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: edges u = b - a, v = c - a, w = c - b.
      for (int k = 0; k < 3; k++) begin
        u[k] <= clfw_pkg::DIFF_W'($signed(in_face.p[1][k]))
              - clfw_pkg::DIFF_W'($signed(in_face.p[0][k]));
        v[k] <= clfw_pkg::DIFF_W'($signed(in_face.p[2][k]))
              - clfw_pkg::DIFF_W'($signed(in_face.p[0][k]));
        w[k] <= clfw_pkg::DIFF_W'($signed(in_face.p[2][k]))
              - clfw_pkg::DIFF_W'($signed(in_face.p[1][k]));
      end
      idx1 <= in_face.idx;

      // Stage 2: products for the cross product and the three dot products.
      px[0] <= u[1] * v[2];
      px[1] <= u[2] * v[1];
      px[2] <= u[2] * v[0];
      px[3] <= u[0] * v[2];
      px[4] <= u[0] * v[1];
      px[5] <= u[1] * v[0];
      for (int k = 0; k < 3; k++) begin
        pd[k]     <= u[k] * v[k];
        pd[3 + k] <= u[k] * w[k];
        pd[6 + k] <= v[k] * w[k];
      end
      idx2 <= idx1;

      // Stage 3: cross product and corner dot products.
      c[0] <= clfw_pkg::CROSS_W'(px[0]) - clfw_pkg::CROSS_W'(px[1]);
      c[1] <= clfw_pkg::CROSS_W'(px[2]) - clfw_pkg::CROSS_W'(px[3]);
      c[2] <= clfw_pkg::CROSS_W'(px[4]) - clfw_pkg::CROSS_W'(px[5]);
      side3.idx    <= idx2;
      side3.dot[0] <= clfw_pkg::DOT_W'(pd[0]) + clfw_pkg::DOT_W'(pd[1])
                    + clfw_pkg::DOT_W'(pd[2]);
      side3.dot[1] <= -(clfw_pkg::DOT_W'(pd[3]) + clfw_pkg::DOT_W'(pd[4])
                    + clfw_pkg::DOT_W'(pd[5]));
      side3.dot[2] <= clfw_pkg::DOT_W'(pd[6]) + clfw_pkg::DOT_W'(pd[7])
                    + clfw_pkg::DOT_W'(pd[8]);

      // Stage 4: magnitudes of the cross components.
      for (int k = 0; k < 3; k++) begin
        m[k] <= clfw_pkg::MAG_W'(c[k][clfw_pkg::CROSS_W-1] ? -c[k] : c[k]);
      end
      side4 <= side3;

      // Stage 5: half-word partial products of each square.
      for (int k = 0; k < 3; k++) begin
        hh[k] <= m[k][clfw_pkg::MAG_W-1:clfw_pkg::HALF_W]
               * m[k][clfw_pkg::MAG_W-1:clfw_pkg::HALF_W];
        hl[k] <= m[k][clfw_pkg::MAG_W-1:clfw_pkg::HALF_W]
               * m[k][clfw_pkg::HALF_W-1:0];
        ll[k] <= m[k][clfw_pkg::HALF_W-1:0] * m[k][clfw_pkg::HALF_W-1:0];
      end
      side5 <= side4;

      // Stage 6: assemble each square.
      for (int k = 0; k < 3; k++) begin
        sq[k] <= (clfw_pkg::SQ_W'(hh[k]) << (2 * clfw_pkg::HALF_W))
               + (clfw_pkg::SQ_W'(hl[k]) << (clfw_pkg::HALF_W + 1))
               + clfw_pkg::SQ_W'(ll[k]);
      end
      side6 <= side5;

      // Stage 7: squared length of the cross product.
      out_s    <= sq[0] + sq[1] + sq[2];
      out_side <= side6;
    end
  end

  assign out_valid = vld[6];

endmodule

`default_nettype wire

>>> hdl/clfw_sqrt.sv
// Pipelined integer square root, one result bit per register stage, with the
// corner data carried alongside. Uses clfw_pkg.
`default_nettype none

module clfw_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [clfw_pkg::SQ_W-1:0]     in_s,
  input  clfw_pkg::side_t               in_side,
  output logic                          out_valid,
  output logic [clfw_pkg::ROOT_W-1:0]   out_root,
  output clfw_pkg::side_t               out_side
);

  logic [clfw_pkg::ROOT_W-1:0] vld;
  logic [clfw_pkg::REM_W-1:0]  rem [0:clfw_pkg::ROOT_W];
  logic [clfw_pkg::ROOT_W-1:0] res [0:clfw_pkg::ROOT_W];
  clfw_pkg::side_t             sd  [0:clfw_pkg::ROOT_W];

  assign rem[0] = clfw_pkg::REM_W'(in_s);
  assign res[0] = '0;
  assign sd[0]  = in_side;

  // Valid bits travel with the stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[clfw_pkg::ROOT_W-2:0], in_valid};
    end
  end

  // Each stage tries the next root bit against the remaining radicand.
  for (genvar k = 0; k < clfw_pkg::ROOT_W; k++) begin : g_step
    localparam int B = clfw_pkg::ROOT_W - 1 - k;
    logic [clfw_pkg::REM_W-1:0] trial;
    logic                       take;

    always_comb begin
      trial = (clfw_pkg::REM_W'(res[k]) << (B + 1)) | (clfw_pkg::REM_W'(1) << (2 * B));
      take  = rem[k] >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k + 1] <= take ? rem[k] - trial : rem[k];
        res[k + 1] <= take ? (res[k] | (clfw_pkg::ROOT_W'(1) << B)) : res[k];
        sd[k + 1]  <= sd[k];
      end
    end
  end

  assign out_valid = vld[clfw_pkg::ROOT_W-1];
  assign out_root  = res[clfw_pkg::ROOT_W];
  assign out_side  = sd[clfw_pkg::ROOT_W];

endmodule

`default_nettype wire

>>> hdl/clfw_div.sv
// Pipelined restoring dividers, three corner lanes, that turn each dot product
// and the cross length into a rounded, capped cotangent. Uses clfw_pkg.
`default_nettype none

module clfw_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [clfw_pkg::ROOT_W-1:0]   in_n,
  input  clfw_pkg::side_t               in_side,
  output logic                          out_valid,
  output clfw_pkg::cot_t                out_cot
);

  localparam int CMP_W = clfw_pkg::ROOT_W + clfw_pkg::DIV_SHIFT;

  typedef struct packed {
    logic [2:0]                               neg;
    logic [2:0]                               ovf;
    logic [2:0]                               zero;
    logic [2:0][clfw_pkg::DIV_SHIFT-1:0]      mlo;
    logic [clfw_pkg::ROOT_W-1:0]              n;
    logic [2:0][clfw_pkg::IDX_W-1:0]          idx;
  } div_meta_t;

  logic [clfw_pkg::QUO_W+1:0]  vld;
  logic [clfw_pkg::DOT_W-1:0]  mi [3];
  logic [clfw_pkg::ROOT_W-1:0] r  [0:clfw_pkg::QUO_W][0:2];
  logic [clfw_pkg::QUO_W-1:0]  q  [0:clfw_pkg::QUO_W][0:2];
  div_meta_t                   meta [0:clfw_pkg::QUO_W];

  function automatic logic [clfw_pkg::COT_W-1:0] cot_of(
    input logic [clfw_pkg::QUO_W-1:0]  qv,
    input logic [clfw_pkg::ROOT_W-1:0] rv,
    input logic [clfw_pkg::ROOT_W-1:0] nv,
    input logic                        negv,
    input logic                        ovfv,
    input logic                        zerov
  );
    logic                          rnd;
    logic [clfw_pkg::COT_MAG_W-1:0] mag;
    logic [clfw_pkg::COT_W-1:0]     val;
    rnd = {rv, 1'b0} >= {1'b0, nv};
    if (ovfv) begin
      mag = zerov ? '0 : clfw_pkg::COT_CAP;
    end else begin
      mag = {1'b0, qv} + clfw_pkg::COT_MAG_W'(rnd);
    end
    val = {1'b0, mag};
    return negv ? -val : val;
  endfunction

  // Valid bits: entry stage, one per quotient bit, rounding stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[clfw_pkg::QUO_W:0], in_valid};
    end
  end

  // Dot magnitudes.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mi[l] = in_side.dot[l][clfw_pkg::DOT_W-1] ? -in_side.dot[l] : in_side.dot[l];
    end
  end

  // Entry stage: overflow check and the high part of the dividend.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        meta[0].neg[l]  <= in_side.dot[l][clfw_pkg::DOT_W-1];
        meta[0].zero[l] <= (mi[l] == '0);
        meta[0].ovf[l]  <= (in_n == '0) ||
                           (CMP_W'(mi[l]) >= {in_n, {clfw_pkg::DIV_SHIFT{1'b0}}});
        meta[0].mlo[l]  <= mi[l][clfw_pkg::DIV_SHIFT-1:0];
        r[0][l]         <= clfw_pkg::ROOT_W'(mi[l][clfw_pkg::DOT_W-1:clfw_pkg::DIV_SHIFT]);
        q[0][l]         <= '0;
      end
      meta[0].n   <= in_n;
      meta[0].idx <= in_side.idx;
    end
  end

  // One quotient bit per stage in each lane.
  for (genvar j = 0; j < clfw_pkg::QUO_W; j++) begin : g_step
    localparam int BIT = clfw_pkg::QUO_W - 1 - j;
    logic [clfw_pkg::QUO_W-1:0]  dvd [3];
    logic [clfw_pkg::ROOT_W:0]   t   [3];
    logic                        ge  [3];

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        dvd[l] = {meta[j].mlo[l], {clfw_pkg::FRAC_W{1'b0}}};
        t[l]   = {r[j][l], dvd[l][BIT]};
        ge[l]  = t[l] >= {1'b0, meta[j].n};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          r[j + 1][l] <= ge[l] ? clfw_pkg::ROOT_W'(t[l] - {1'b0, meta[j].n})
                               : t[l][clfw_pkg::ROOT_W-1:0];
          q[j + 1][l] <= {q[j][l][clfw_pkg::QUO_W-2:0], ge[l]};
        end
        meta[j + 1] <= meta[j];
      end
    end
  end

  // Rounding stage: round half away from zero, cap, apply sign.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        out_cot.cot[l]  <= cot_of(q[clfw_pkg::QUO_W][l], r[clfw_pkg::QUO_W][l],
                                  meta[clfw_pkg::QUO_W].n, meta[clfw_pkg::QUO_W].neg[l],
                                  meta[clfw_pkg::QUO_W].ovf[l],
                                  meta[clfw_pkg::QUO_W].zero[l]);
        out_cot.flag[l] <= meta[clfw_pkg::QUO_W].ovf[l];
      end
      out_cot.idx <= meta[clfw_pkg::QUO_W].idx;
    end
  end

  assign out_valid = vld[clfw_pkg::QUO_W+1];

endmodule

`default_nettype wire

>>> hdl/clfw_emit.sv
// Triplet emitter: forms the nine weights of a face when it loads and sends
// them out one per cycle while trip.ready is high. Uses clfw_pkg and clfw_trip_if.
`default_nettype none

module clfw_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  clfw_pkg::cot_t       in_cot,
  input  logic                 mode,
  output logic                 in_ready,
  clfw_trip_if.source          trip
);

  typedef struct packed {
    logic [clfw_pkg::WGT_W-1:0] w;
    logic                       clip;
  } wclip_t;

  logic                             busy;
  logic [clfw_pkg::SLOT_W-1:0]      cnt;
  logic                             load;
  logic                             uniform;
  logic [clfw_pkg::IDX_W-1:0]       row  [clfw_pkg::SLOT_N];
  logic [clfw_pkg::IDX_W-1:0]       col  [clfw_pkg::SLOT_N];
  logic [clfw_pkg::WGT_W-1:0]       wt   [clfw_pkg::SLOT_N];
  logic                             sat  [clfw_pkg::SLOT_N];
  logic [clfw_pkg::IDX_W-1:0]       row_next [clfw_pkg::SLOT_N];
  logic [clfw_pkg::IDX_W-1:0]       col_next [clfw_pkg::SLOT_N];
  logic [clfw_pkg::WGT_W-1:0]       wt_next  [clfw_pkg::SLOT_N];
  logic                             sat_next [clfw_pkg::SLOT_N];

  function automatic wclip_t clip_w(input logic [clfw_pkg::COT_W:0] x);
    wclip_t o;
    if ((x[clfw_pkg::COT_W:clfw_pkg::WGT_W-1] == '0) ||
        (x[clfw_pkg::COT_W:clfw_pkg::WGT_W-1] == '1)) begin
      o.w    = x[clfw_pkg::WGT_W-1:0];
      o.clip = 1'b0;
    end else begin
      o.w    = x[clfw_pkg::COT_W] ? clfw_pkg::WGT_NEG_MAX : clfw_pkg::WGT_POS_MAX;
      o.clip = 1'b1;
    end
    return o;
  endfunction

  // Nine triplets of the incoming face, corner by corner.
  always_comb begin
    int     i1;
    int     i2;
    logic [clfw_pkg::COT_W:0] c1;
    logic [clfw_pkg::COT_W:0] c2;
    wclip_t d;
    wclip_t n1;
    wclip_t n2;
    for (int i = 0; i < 3; i++) begin
      i1 = (i == 2) ? 0 : i + 1;
      i2 = (i == 0) ? 2 : i - 1;
      c1 = {in_cot.cot[i1][clfw_pkg::COT_W-1], in_cot.cot[i1]};
      c2 = {in_cot.cot[i2][clfw_pkg::COT_W-1], in_cot.cot[i2]};
      d  = clip_w(c1 + c2);
      n1 = clip_w(-c2);
      n2 = clip_w(-c1);
      row_next[3 * i]     = in_cot.idx[i];
      row_next[3 * i + 1] = in_cot.idx[i];
      row_next[3 * i + 2] = in_cot.idx[i];
      col_next[3 * i]     = in_cot.idx[i];
      col_next[3 * i + 1] = in_cot.idx[i1];
      col_next[3 * i + 2] = in_cot.idx[i2];
      if (mode) begin
        wt_next[3 * i]      = clfw_pkg::WGT_ONE;
        wt_next[3 * i + 1]  = clfw_pkg::WGT_HALF_NEG;
        wt_next[3 * i + 2]  = clfw_pkg::WGT_HALF_NEG;
        sat_next[3 * i]     = 1'b0;
        sat_next[3 * i + 1] = 1'b0;
        sat_next[3 * i + 2] = 1'b0;
      end else begin
        wt_next[3 * i]      = d.w;
        wt_next[3 * i + 1]  = n1.w;
        wt_next[3 * i + 2]  = n2.w;
        sat_next[3 * i]     = d.clip || in_cot.flag[i1] || in_cot.flag[i2];
        sat_next[3 * i + 1] = n1.clip || in_cot.flag[i2];
        sat_next[3 * i + 2] = n2.clip || in_cot.flag[i1];
      end
    end
  end

  // A new face loads when the buffer is empty or its last triplet leaves.
  assign in_ready = !busy || (trip.ready && (cnt == clfw_pkg::LAST_SLOT));
  assign load     = in_valid && in_ready;

  // Slot counter and buffer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (busy && trip.ready) begin
      if (cnt == clfw_pkg::LAST_SLOT) begin
        busy <= load;
        cnt  <= '0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end
  end

  // Triplet buffer.
  always_ff @(posedge clk) begin
    if (load) begin
      row     <= row_next;
      col     <= col_next;
      wt      <= wt_next;
      sat     <= sat_next;
      uniform <= mode;
    end
  end

  assign trip.valid        = busy;
  assign trip.row_index    = row[cnt];
  assign trip.col_index    = col[cnt];
  assign trip.weight       = wt[cnt];
  assign trip.saturated    = sat[cnt];
  assign trip.last_of_face = (cnt == clfw_pkg::LAST_SLOT);

`ifndef SYNTHESIS
  // Diagonal triplets sit on the row's own vertex.
  a_diag: assert property (@(posedge clk) disable iff (rst)
    busy && (cnt == 4'd0 || cnt == 4'd3 || cnt == 4'd6) |-> trip.row_index == trip.col_index)
    else $error("diagonal triplet with row and column apart");

  // Uniform weights are never flagged.
  a_uni: assert property (@(posedge clk) disable iff (rst)
    busy && uniform |-> !trip.saturated)
    else $error("saturated flag in uniform mode");

  // After the last triplet leaves with nothing waiting, the buffer is empty.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    busy && trip.ready && (cnt == clfw_pkg::LAST_SLOT) && !in_valid |=> !busy)
    else $error("buffer stayed full after its last triplet");
`endif

endmodule

`default_nettype wire

>>> hdl/cotangent_laplacian_face_weights_top.sv
// Top level of the cotangent Laplacian face weight block: front arithmetic,
// square root, dividers and triplet emitter. Uses clfw_pkg and clfw_if.
//
//   channel | dir | accepted when         | item
//   face    | in  | face.valid & ready    | triangle: three indices, nine coordinates
//   trip    | out | trip.valid & ready    | triplet: row, column, weight, flags
//   cfg     | in  | cfg_we                | weight_mode bit
//
// Each face yields nine triplets, sent back to back while trip.ready is high,
// so the single output port limits how fast faces leave. From acceptance to the
// first triplet a face passes 7 front stages, 51 root stages, 42 divider stages
// and the emitter load. Reset is synchronous and clears the valid bits, the
// emitter and weight_mode. The whole pipeline halts while a finished face waits
// on a full emitter, so a stall on the result side loses and repeats no item.
`default_nettype none

module cotangent_laplacian_face_weights_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  clfw_face_if.sink     face,
  clfw_trip_if.source   trip
);

  logic                          weight_mode;
  logic                          adv;
  logic                          emit_ready;
  clfw_pkg::face_t               face_data;
  logic                          front_valid;
  logic [clfw_pkg::SQ_W-1:0]     front_s;
  clfw_pkg::side_t               front_side;
  logic                          root_valid;
  logic [clfw_pkg::ROOT_W-1:0]   root_n;
  clfw_pkg::side_t               root_side;
  logic                          div_valid;
  clfw_pkg::cot_t                div_cot;

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      weight_mode <= 1'b0;
    end else if (cfg_we) begin
      weight_mode <= cfg_wdata;
    end
  end

  // The pipeline moves unless a finished face waits on a full emitter.
  assign adv        = !div_valid || emit_ready;
  assign face.ready = adv;

  assign face_data.idx = {face.index_c, face.index_b, face.index_a};
  assign face_data.p   = {face.c_z, face.c_y, face.c_x,
                          face.b_z, face.b_y, face.b_x,
                          face.a_z, face.a_y, face.a_x};

  clfw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (face.valid),
    .in_face   (face_data),
    .out_valid (front_valid),
    .out_s     (front_s),
    .out_side  (front_side)
  );

  clfw_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (front_valid),
    .in_s      (front_s),
    .in_side   (front_side),
    .out_valid (root_valid),
    .out_root  (root_n),
    .out_side  (root_side)
  );

  clfw_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (root_valid),
    .in_n      (root_n),
    .in_side   (root_side),
    .out_valid (div_valid),
    .out_cot   (div_cot)
  );

  clfw_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .in_valid (div_valid),
    .in_cot   (div_cot),
    .mode     (weight_mode),
    .in_ready (emit_ready),
    .trip     (trip)
  );

endmodule

`default_nettype wire

>>> tb/tb_cotangent_laplacian_face_weights_top.sv
// Testbench for the cotangent Laplacian face weight block: directed and random
// triangles in both weight modes, each triplet checked against a local predictor.
// Depends on hdl/clfw_pkg.sv, hdl/clfw_if.sv and the top level of the block.
`timescale 1ns / 1ps

module tb_cotangent_laplacian_face_weights_top;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 150;
  localparam longint CAP        = longint'(1) << 40;

  typedef enum logic { MODE_COT = 1'b0, MODE_UNIFORM = 1'b1 } mode_e;

  typedef struct {
    logic [15:0] row;
    logic [15:0] col;
    logic [31:0] weight;
    logic        sat;
    logic        last;
  } triplet_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  clfw_face_if face_ch ();
  clfw_trip_if trip_ch ();

  cotangent_laplacian_face_weights_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .face     (face_ch),
    .trip     (trip_ch)
  );

  triplet_t expected_triplets[$];
  mode_e    cur_mode;
  int       errors;
  int       faces_sent;
  int       triplets_seen;
  int       sat_seen;
  bit       burst;
  int       idle_cycles;
  int       stall_left;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Integer square root, floor, by bit-by-bit trial.
  function automatic logic [127:0] isqrt(logic [127:0] s);
    logic [127:0] res;
    logic [127:0] cand;
    res = '0;
    for (int b = 52; b >= 0; b--) begin
      cand = res | (128'd1 << b);
      if (cand * cand <= s) res = cand;
    end
    return res;
  endfunction

  // Cotangent in 16 fraction bits from a corner dot product and the doubled area.
  function automatic longint corner_cot(longint d, logic [127:0] n, output bit fl);
    logic [127:0] m;
    logic [127:0] num;
    logic [127:0] q;
    logic [127:0] r;
    fl = 1'b0;
    m = (d < 0) ? 128'(-d) : 128'(d);
    if (n == 0) begin
      fl = 1'b1;
      return (d > 0) ? CAP : ((d < 0) ? -CAP : 0);
    end
    if (m / n >= (128'd1 << 24)) begin
      fl = 1'b1;
      q = 128'(CAP);
    end else begin
      num = m << 16;
      q = num / n;
      r = num % n;
      if (2 * r >= n) q = q + 1;
      if (q > 128'(CAP)) begin
        q = 128'(CAP);
        fl = 1'b1;
      end
    end
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Clamp a weight into the signed 32-bit range.
  function automatic logic [31:0] clamp_weight(longint w, inout bit fl);
    if (w > 64'sd2147483647) begin
      fl = 1'b1;
      return clfw_pkg::WGT_POS_MAX;
    end
    if (w < -64'sd2147483648) begin
      fl = 1'b1;
      return clfw_pkg::WGT_NEG_MAX;
    end
    return w[31:0];
  endfunction

  // Work out the nine triplets of one triangle and queue them.
  task automatic predict_triplets(clfw_pkg::face_t f);
    longint p[3][3];
    longint u[3];
    longint v[3];
    longint cr[3];
    longint cot[3];
    bit cf[3];
    logic [127:0] s;
    logic [127:0] a;
    logic [127:0] n;
    longint d;
    longint w[3];
    bit fl[3];
    logic [15:0] cols[3];
    int i1;
    int i2;
    int t;
    triplet_t tr;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) p[i][k] = longint'($signed(f.p[i][k]));
    for (int k = 0; k < 3; k++) begin
      u[k] = p[1][k] - p[0][k];
      v[k] = p[2][k] - p[0][k];
    end
    cr[0] = u[1] * v[2] - u[2] * v[1];
    cr[1] = u[2] * v[0] - u[0] * v[2];
    cr[2] = u[0] * v[1] - u[1] * v[0];
    s = '0;
    for (int k = 0; k < 3; k++) begin
      a = (cr[k] < 0) ? 128'(-cr[k]) : 128'(cr[k]);
      s = s + a * a;
    end
    n = isqrt(s);
    for (int i = 0; i < 3; i++) begin
      i1 = (i + 1) % 3;
      i2 = (i + 2) % 3;
      d = 0;
      for (int k = 0; k < 3; k++) d += (p[i1][k] - p[i][k]) * (p[i2][k] - p[i][k]);
      cot[i] = corner_cot(d, n, cf[i]);
    end
    t = 0;
    for (int i = 0; i < 3; i++) begin
      i1 = (i + 1) % 3;
      i2 = (i + 2) % 3;
      cols[0] = f.idx[i];
      cols[1] = f.idx[i1];
      cols[2] = f.idx[i2];
      for (int k = 0; k < 3; k++) begin
        tr.row = f.idx[i];
        tr.col = cols[k];
        if (cur_mode == MODE_UNIFORM) begin
          tr.weight = (k == 0) ? clfw_pkg::WGT_ONE : clfw_pkg::WGT_HALF_NEG;
          tr.sat = 1'b0;
        end else begin
          fl[0] = cf[i1] || cf[i2];
          fl[1] = cf[i2];
          fl[2] = cf[i1];
          w[0] = cot[i1] + cot[i2];
          w[1] = -cot[i2];
          w[2] = -cot[i1];
          tr.weight = clamp_weight(w[k], fl[k]);
          tr.sat = fl[k];
        end
        tr.last = (t == clfw_pkg::SLOT_N - 1);
        expected_triplets.insert(expected_triplets.size(), tr);
        t++;
      end
    end
  endtask

  // Send one triangle: optional gap, then hold valid until accepted.
  task automatic send_face(clfw_pkg::face_t f);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      face_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    face_ch.valid   <= 1'b1;
    face_ch.index_a <= f.idx[0];
    face_ch.index_b <= f.idx[1];
    face_ch.index_c <= f.idx[2];
    face_ch.a_x <= f.p[0][0];
    face_ch.a_y <= f.p[0][1];
    face_ch.a_z <= f.p[0][2];
    face_ch.b_x <= f.p[1][0];
    face_ch.b_y <= f.p[1][1];
    face_ch.b_z <= f.p[1][2];
    face_ch.c_x <= f.p[2][0];
    face_ch.c_y <= f.p[2][1];
    face_ch.c_z <= f.p[2][2];
    do @(posedge clk); while (!face_ch.ready);
    predict_triplets(f);
    faces_sent++;
  endtask

  // Lower valid and wait until every queued triplet has arrived.
  task automatic wait_drained();
    face_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_triplets.size() != 0) @(posedge clk);
  endtask

  // Change the weight mode once the pipeline is empty.
  task automatic write_mode(mode_e m);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_mode  = m;
  endtask

  function automatic clfw_pkg::face_t mk_face(logic [15:0] ia, logic [15:0] ib,
                                              logic [15:0] ic,
                                              longint ax, longint ay, longint az,
                                              longint bx, longint by, longint bz,
                                              longint cx, longint cy, longint cz);
    clfw_pkg::face_t f;
    f.idx[0] = ia; f.idx[1] = ib; f.idx[2] = ic;
    f.p[0][0] = ax[23:0]; f.p[0][1] = ay[23:0]; f.p[0][2] = az[23:0];
    f.p[1][0] = bx[23:0]; f.p[1][1] = by[23:0]; f.p[1][2] = bz[23:0];
    f.p[2][0] = cx[23:0]; f.p[2][1] = cy[23:0]; f.p[2][2] = cz[23:0];
    return f;
  endfunction

  // Random triangle: full range, small, thin or degenerate.
  function automatic clfw_pkg::face_t rand_face();
    clfw_pkg::face_t f;
    int kind;
    int sp;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) f.idx[i] = 16'($urandom());
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) f.p[i][k] = 24'($urandom());
    if (kind >= 3 && kind <= 6) begin
      // Small coordinates around a random center.
      sp = 1 << $urandom_range(2, 16);
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 3; k++)
          f.p[i][k] = f.p[0][k] + 24'($signed($urandom_range(0, 2 * sp)) - sp);
    end else if (kind == 7 || kind == 8) begin
      // Thin triangle: c sits next to the midpoint of a and b.
      for (int k = 0; k < 3; k++)
        f.p[2][k] = 24'((longint'($signed(f.p[0][k])) + longint'($signed(f.p[1][k]))) / 2
                        + longint'($urandom_range(0, 2)) - 1);
    end else if (kind == 9) begin
      // Degenerate: two corners coincide.
      f.p[$urandom_range(1, 2)] = f.p[0];
    end
    return f;
  endfunction

  // Result side: check each accepted triplet and draw a stall for the next one.
  always @(posedge clk) begin
    triplet_t e;
    int n;
    if (rst) begin
      trip_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (trip_ch.valid && trip_ch.ready) begin
      triplets_seen++;
      if (trip_ch.saturated) sat_seen++;
      if (expected_triplets.size() == 0) begin
        $display("%0t: unexpected triplet row %h col %h weight %h", $time,
                 trip_ch.row_index, trip_ch.col_index, trip_ch.weight);
        errors++;
      end else begin
        e = expected_triplets.pop_front();
        if (trip_ch.row_index !== e.row) begin
          $display("%0t: row_index expected %h actual %h", $time, e.row, trip_ch.row_index);
          errors++;
        end
        if (trip_ch.col_index !== e.col) begin
          $display("%0t: col_index expected %h actual %h", $time, e.col, trip_ch.col_index);
          errors++;
        end
        if (trip_ch.weight !== e.weight) begin
          $display("%0t: weight expected %h actual %h", $time, e.weight, trip_ch.weight);
          errors++;
        end
        if (trip_ch.saturated !== e.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, e.sat, trip_ch.saturated);
          errors++;
        end
        if (trip_ch.last_of_face !== e.last) begin
          $display("%0t: last_of_face expected %b actual %b", $time, e.last,
                   trip_ch.last_of_face);
          errors++;
        end
      end
      n = burst ? 0 : $urandom_range(0, 9);
      if (n == 0) begin
        trip_ch.ready <= 1'b1;
      end else begin
        trip_ch.ready <= 1'b0;
        stall_left = n;
      end
    end else if (!trip_ch.ready) begin
      if (stall_left <= 1) trip_ch.ready <= 1'b1;
      else stall_left--;
    end
  end

  // Watchdog on cycles with no accepted item on either channel.
  always @(posedge clk) begin
    if (rst || (face_ch.valid && face_ch.ready) || (trip_ch.valid && trip_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, %0d triplets outstanding", $time, expected_triplets.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Corner cases in cotangent mode.
  task automatic test_cot_directed();
    send_face(mk_face(0, 1, 2, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
    send_face(mk_face(65535, 0, 65535, 0, 0, 0, 8192, 0, 0, 4096, 7094, 0));
    send_face(mk_face(7, 8, 9, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_face(mk_face(3, 4, 5, 0, 0, 0, 4096, 0, 0, 8192, 0, 0));
    send_face(mk_face(10, 11, 12, 5, 5, 5, 5, 5, 5, 900, -3, 77));
    send_face(mk_face(1, 2, 3, -8388608, 0, 0, 8388607, 0, 0, 0, 1, 0));
    send_face(mk_face(4, 5, 6, -8388608, 0, 0, 8388607, 0, 0, 0, 200, 0));
    send_face(mk_face(65535, 65534, 65533, 8388607, 8388607, 8388607,
                      -8388608, -8388608, -8388608, 8388607, -8388608, 8388607));
    send_face(mk_face(0, 0, 0, -8388608, -8388608, -8388608,
                      8388607, -8388608, -8388608, -8388608, 8388607, 8388607));
    send_face(mk_face(20, 21, 22, 0, 0, 0, 10000, 0, 0, -3000, 50, 0));
    send_face(mk_face(23, 24, 25, 100, 200, 300, -400, 500, -600, 700, -800, 900));
    send_face(mk_face(26, 27, 28, 1, 0, 0, 0, 1, 0, 0, 0, 1));
  endtask

  // Uniform weights, including a degenerate face.
  task automatic test_uniform_directed();
    write_mode(MODE_UNIFORM);
    send_face(mk_face(0, 65535, 1, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
    send_face(mk_face(9, 9, 9, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_face(mk_face(5, 6, 7, -8388608, 0, 0, 8388607, 0, 0, 0, 1, 0));
    write_mode(MODE_COT);
  endtask

  // Random faces in alternating modes, with bursts, a mid-run drain and a drain before each mode change.
  task automatic test_random();
    for (int i = 0; i < 90; i++) begin
      burst = (i >= 40 && i < 55);
      send_face(rand_face());
      if (i == 60) wait_drained();
    end
    burst = 1'b0;
    write_mode(MODE_UNIFORM);
    for (int i = 0; i < 40; i++) send_face(rand_face());
    write_mode(MODE_COT);
    for (int i = 0; i < 90; i++) begin
      burst = (i >= 20 && i < 35);
      send_face(rand_face());
    end
    burst = 1'b0;
  endtask

  // Main sequence.
  initial begin
    errors = 0;
    faces_sent = 0;
    triplets_seen = 0;
    sat_seen = 0;
    burst = 1'b0;
    cur_mode = MODE_COT;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    face_ch.valid <= 1'b0;
    face_ch.index_a <= '0;
    face_ch.index_b <= '0;
    face_ch.index_c <= '0;
    face_ch.a_x <= '0;
    face_ch.a_y <= '0;
    face_ch.a_z <= '0;
    face_ch.b_x <= '0;
    face_ch.b_y <= '0;
    face_ch.b_z <= '0;
    face_ch.c_x <= '0;
    face_ch.c_y <= '0;
    face_ch.c_z <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_cot_directed();
    test_uniform_directed();
    test_random();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d faces in both weight modes, %0d triplets checked, %0d saturated.",
             faces_sent, triplets_seen, sat_seen);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches found", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/clfw_pkg.sv
hdl/clfw_if.sv
hdl/clfw_front.sv
hdl/clfw_sqrt.sv
hdl/clfw_div.sv
hdl/clfw_emit.sv
hdl/cotangent_laplacian_face_weights_top.sv
tb/tb_cotangent_laplacian_face_weights_top.sv
